@@ rtl/sha1md_pkg.sv @@
`default_nettype none

package sha1md_pkg;

  // One 32-bit message word on its way from the front end to the compression core.
  // The last flag marks the final word of a padded message.
  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } q_entry_t;

  localparam int unsigned WordsPerBlock  = 16;
  localparam int unsigned RoundsPerBlock = 80;
  localparam int unsigned DigestWords    = 5;

  localparam logic [7:0] PadMark = 8'h80;

  localparam logic [31:0] RoundK0 = 32'h5a827999;
  localparam logic [31:0] RoundK1 = 32'h6ed9eba1;
  localparam logic [31:0] RoundK2 = 32'h8f1bbcdc;
  localparam logic [31:0] RoundK3 = 32'hca62c1d6;

  localparam logic [31:0] InitChain [DigestWords] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

endpackage

`default_nettype wire

@@ rtl/sha1md_fifo.sv @@
`default_nettype none

module sha1md_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  sha1md_pkg::q_entry_t  entry_i,
  output logic                  full_o,
  input  wire                   pop_i,
  output sha1md_pkg::q_entry_t  entry_o,
  output logic                  empty_o
);
  import sha1md_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  q_entry_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/sha1md_front.sv @@
`default_nettype none

module sha1md_front (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire  [7:0]            data_byte_i,
  input  wire                   has_byte_i,
  input  wire                   end_of_message_i,
  input  wire                   in_push_i,
  output logic                  in_full_o,
  output logic                  q_push_o,
  output sha1md_pkg::q_entry_t  q_entry_o,
  input  wire                   q_full_i
);
  import sha1md_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_PAD  = 2'b10
  } f_state_e;

  f_state_e    st_q, st_d;
  logic [63:0] cnt_q, cnt_d, cnt_inc, cnt_new;
  logic [23:0] acc_q, acc_d;
  logic [3:0]  pidx_q, pidx_d;
  logic        first_q, first_d;
  logic        extra_q, extra_d;
  logic [31:0] pad_word;
  logic [63:0] bit_len;
  logic        pad_last;

  assign cnt_inc = cnt_q + 64'd1;
  assign cnt_new = has_byte_i ? cnt_inc : cnt_q;
  assign bit_len = {cnt_q[60:0], 3'b000};

  // Only the most recent bytes of the partial word live in the low lanes of acc_q.
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    pad_word = {PadMark, 24'h000000};
      2'd1:    pad_word = {acc_q[7:0], PadMark, 16'h0000};
      2'd2:    pad_word = {acc_q[15:0], PadMark, 8'h00};
      default: pad_word = {acc_q, PadMark};
    endcase
  end

  assign pad_last = !first_q && !extra_q && (pidx_q == 4'd15);

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    pidx_d    = pidx_q;
    first_d   = first_q;
    extra_d   = extra_q;
    q_push_o  = 1'b0;
    q_entry_o = '{word: {acc_q, data_byte_i}, last: 1'b0};
    in_full_o = (st_q != F_IDLE) || q_full_i;
    unique case (st_q)
      F_IDLE: begin
        if (in_push_i && !in_full_o) begin
          if (has_byte_i) begin
            acc_d = {acc_q[15:0], data_byte_i};
            cnt_d = cnt_inc;
            if (cnt_q[1:0] == 2'd3) begin
              q_push_o = 1'b1;
            end
          end
          if (end_of_message_i) begin
            st_d    = F_PAD;
            pidx_d  = cnt_new[5:2];
            first_d = 1'b1;
            // With fewer than nine bytes of room left, the length goes in an extra block.
            extra_d = (cnt_new[5:3] == 3'b111);
          end
        end
      end
      F_PAD: begin
        if (first_q) begin
          q_entry_o.word = pad_word;
        end else if (extra_q || (pidx_q < 4'd14)) begin
          q_entry_o.word = 32'h0;
        end else if (pidx_q == 4'd14) begin
          q_entry_o.word = bit_len[63:32];
        end else begin
          q_entry_o.word = bit_len[31:0];
        end
        q_entry_o.last = pad_last;
        if (!q_full_i) begin
          q_push_o = 1'b1;
          first_d  = 1'b0;
          pidx_d   = pidx_q + 4'd1;
          if (pidx_q == 4'd15) begin
            extra_d = 1'b0;
          end
          if (pad_last) begin
            st_d  = F_IDLE;
            cnt_d = '0;
          end
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= F_IDLE;
      cnt_q   <= '0;
      pidx_q  <= '0;
      first_q <= 1'b0;
      extra_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      pidx_q  <= pidx_d;
      first_q <= first_d;
      extra_q <= extra_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

`default_nettype wire

@@ rtl/sha1md_core.sv @@
`default_nettype none

module sha1md_core (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  sha1md_pkg::q_entry_t  q_entry_i,
  input  wire                   q_empty_i,
  output logic                  q_pop_o,
  output logic [31:0]           digest_word_o,
  output logic                  last_word_o,
  output logic                  out_empty_o,
  input  wire                   out_pop_i
);
  import sha1md_pkg::*;

  typedef enum logic [1:0] {
    B_ROUND = 2'b01,
    B_ADD   = 2'b10
  } b_state_e;

  localparam logic [6:0] LastRound = 7'(RoundsPerBlock - 1);
  localparam logic [6:0] LastLoad  = 7'(WordsPerBlock - 1);
  localparam logic [6:0] FirstSchd = 7'(WordsPerBlock);
  localparam logic [2:0] AllWords  = 3'(DigestWords);

  b_state_e    st_q;
  logic [6:0]  t_q;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] cv_q  [DigestWords];
  logic [31:0] nv    [DigestWords];
  logic [31:0] dig_q [DigestWords];
  logic [31:0] win_q [WordsPerBlock];
  logic        fin_q;
  logic [2:0]  left_q;
  logic [31:0] w_mix, w_new, f_val, k_val, temp;
  logic        step, hold, out_take;

  assign w_mix = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
  assign w_new = (t_q < FirstSchd) ? q_entry_i.word : {w_mix[30:0], w_mix[31]};

  always_comb begin
    if (t_q < 7'd20) begin
      f_val = (b_q & c_q) | (~b_q & d_q);
      k_val = RoundK0;
    end else if (t_q < 7'd40) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = RoundK1;
    end else if (t_q < 7'd60) begin
      f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_val = RoundK2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = RoundK3;
    end
  end

  assign temp = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_new;

  // The first sixteen rounds take their word straight from the queue head.
  assign step    = (st_q == B_ROUND) && ((t_q >= FirstSchd) || !q_empty_i);
  assign q_pop_o = (st_q == B_ROUND) && (t_q < FirstSchd) && !q_empty_i;
  assign hold    = fin_q && (left_q != 3'd0);

  assign nv[0] = cv_q[0] + a_q;
  assign nv[1] = cv_q[1] + b_q;
  assign nv[2] = cv_q[2] + c_q;
  assign nv[3] = cv_q[3] + d_q;
  assign nv[4] = cv_q[4] + e_q;

  assign out_empty_o   = (left_q == 3'd0);
  assign out_take      = out_pop_i && !out_empty_o;
  assign digest_word_o = dig_q[0];
  assign last_word_o   = (left_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= B_ROUND;
      t_q    <= '0;
      fin_q  <= 1'b0;
      left_q <= '0;
      a_q    <= InitChain[0];
      b_q    <= InitChain[1];
      c_q    <= InitChain[2];
      d_q    <= InitChain[3];
      e_q    <= InitChain[4];
      for (int i = 0; i < DigestWords; i++) begin
        cv_q[i] <= InitChain[i];
      end
    end else begin
      if (out_take) begin
        left_q <= left_q - 3'd1;
      end
      unique case (st_q)
        B_ROUND: begin
          if (step) begin
            a_q <= temp;
            b_q <= a_q;
            c_q <= {b_q[1:0], b_q[31:2]};
            d_q <= c_q;
            e_q <= d_q;
            if (t_q == LastLoad) begin
              fin_q <= q_entry_i.last;
            end
            if (t_q == LastRound) begin
              st_q <= B_ADD;
            end else begin
              t_q <= t_q + 7'd1;
            end
          end
        end
        B_ADD: begin
          if (!hold) begin
            if (fin_q) begin
              left_q <= AllWords;
              a_q    <= InitChain[0];
              b_q    <= InitChain[1];
              c_q    <= InitChain[2];
              d_q    <= InitChain[3];
              e_q    <= InitChain[4];
              for (int i = 0; i < DigestWords; i++) begin
                cv_q[i] <= InitChain[i];
              end
            end else begin
              a_q <= nv[0];
              b_q <= nv[1];
              c_q <= nv[2];
              d_q <= nv[3];
              e_q <= nv[4];
              for (int i = 0; i < DigestWords; i++) begin
                cv_q[i] <= nv[i];
              end
            end
            st_q <= B_ROUND;
            t_q  <= '0;
          end
        end
        default: st_q <= B_ROUND;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      for (int i = 0; i < WordsPerBlock - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WordsPerBlock-1] <= w_new;
    end
    if ((st_q == B_ADD) && !hold && fin_q) begin
      for (int i = 0; i < DigestWords; i++) begin
        dig_q[i] <= nv[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < DigestWords - 1; i++) begin
        dig_q[i] <= dig_q[i+1];
      end
    end
  end

  // A padded message must end exactly on a block boundary.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && q_entry_i.last) |-> (t_q == LastLoad))
    else $error("message end word popped off a block boundary");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == B_ADD) && hold) |=> (st_q == B_ADD))
    else $error("final block completed while the previous digest was still pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == B_ADD) && !hold) |=> ((st_q == B_ROUND) && (t_q == 7'd0)))
    else $error("round counter not restarted after chaining update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == B_ADD) && !hold && fin_q) |=> (left_q == AllWords))
    else $error("digest not presented after final block");

endmodule

`default_nettype wire

@@ rtl/sha1_message_digest_unit.sv @@
`default_nettype none

// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-------------------------------------
// message  | in        | push / full         | data_byte_i, has_byte_i, end_of_message_i
// digest   | out       | empty / pop         | digest_word_o, last_word_o
//
// A byte is taken whenever the queue has room and no padding is being pushed; each
// 64-byte block takes the core through 16 rounds fed from the queue, 64 schedule rounds
// and one chaining add. The default four-entry queue holds only 16 bytes while the core
// runs its schedule rounds and chaining add without a pop, so long messages stall the input.
// An end item blocks input while its 3 to 18 padding words are pushed, one per free slot.
// Reset restores the initial chaining value and a zero byte count; there is no clearing pass.
// A pending digest stalls only the last block of the next message.

module sha1_message_digest_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire  [7:0]  data_byte_i,
  input  wire         has_byte_i,
  input  wire         end_of_message_i,
  input  wire         push,
  output logic        full,
  output logic [31:0] digest_word_o,
  output logic        last_word_o,
  output logic        empty,
  input  wire         pop
);
  import sha1md_pkg::*;

  q_entry_t fq_in, fq_out;
  logic     fq_push, fq_full, fq_pop, fq_empty;

  sha1md_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .in_push_i        (push),
    .in_full_o        (full),
    .q_push_o         (fq_push),
    .q_entry_o        (fq_in),
    .q_full_i         (fq_full)
  );

  sha1md_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .entry_i (fq_in),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .entry_o (fq_out),
    .empty_o (fq_empty)
  );

  sha1md_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_entry_i     (fq_out),
    .q_empty_i     (fq_empty),
    .q_pop_o       (fq_pop),
    .digest_word_o (digest_word_o),
    .last_word_o   (last_word_o),
    .out_empty_o   (empty),
    .out_pop_i     (pop)
  );

endmodule

`default_nettype wire

@@ dv/sha1_digest_check_pkg.sv @@
package sha1_digest_check_pkg;

  localparam logic [31:0] K_ROUNDS_0_19  = 32'h5a827999;
  localparam logic [31:0] K_ROUNDS_20_39 = 32'h6ed9eba1;
  localparam logic [31:0] K_ROUNDS_40_59 = 32'h8f1bbcdc;
  localparam logic [31:0] K_ROUNDS_60_79 = 32'hca62c1d6;
  localparam logic [7:0]  PAD_BYTE       = 8'h80;
  localparam int unsigned DIGEST_LEN     = 5;

  typedef struct {
    logic [31:0] word;
    logic        last;
  } digest_word_t;

  // Tracks the hash state of the message in flight and keeps the digest words that the
  // block owes for messages already finished.
  class sha1_expected_digests;
    logic [31:0]  chain [DIGEST_LEN];
    logic [7:0]   block [64];
    logic [31:0]  window [16];
    logic [63:0]  byte_count;
    digest_word_t owed_words [$];
    int unsigned  errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = 32'h67452301;
      chain[1] = 32'hefcdab89;
      chain[2] = 32'h98badcfe;
      chain[3] = 32'h10325476;
      chain[4] = 32'hc3d2e1f0;
      byte_count = '0;
    endfunction

    function logic [31:0] rol(logic [31:0] v, int unsigned n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void compress();
      logic [31:0] a, b, c, d, e, w, f, k, t_sum;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int t = 0; t < 80; t++) begin
        if (t < 16) begin
          w = {block[4*t], block[4*t+1], block[4*t+2], block[4*t+3]};
        end else begin
          w = rol(window[(t-3) & 15] ^ window[(t-8) & 15] ^ window[(t-14) & 15] ^
                  window[t & 15], 1);
        end
        window[t & 15] = w;
        if (t < 20) begin
          f = (b & c) | (~b & d);
          k = K_ROUNDS_0_19;
        end else if (t < 40) begin
          f = b ^ c ^ d;
          k = K_ROUNDS_20_39;
        end else if (t < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K_ROUNDS_40_59;
        end else begin
          f = b ^ c ^ d;
          k = K_ROUNDS_60_79;
        end
        t_sum = rol(a, 5) + f + e + k + w;
        e = d;
        d = c;
        c = rol(b, 30);
        b = a;
        a = t_sum;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void absorb_item(logic [7:0] data, logic has_byte, logic end_msg);
      logic [63:0]  bit_len;
      int unsigned  pos;
      digest_word_t dw;
      if (has_byte) begin
        block[byte_count[5:0]] = data;
        byte_count++;
        if (byte_count[5:0] == 6'd0) compress();
      end
      if (!end_msg) return;
      bit_len = byte_count << 3;
      pos = 32'(byte_count[5:0]);
      block[pos] = PAD_BYTE;
      pos++;
      // The length field no longer fits, so the padding spills into one more block.
      if (pos > 56) begin
        while (pos < 64) begin
          block[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < 56) begin
        block[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++) block[56+i] = bit_len[63-8*i -: 8];
      compress();
      for (int i = 0; i < DIGEST_LEN; i++) begin
        dw.word = chain[i];
        dw.last = (i == DIGEST_LEN - 1);
        owed_words.push_back(dw);
      end
      restart();
    endfunction

    function void check_digest_word(logic [31:0] word, logic last);
      digest_word_t dw;
      if (owed_words.size() == 0) begin
        $error("unexpected digest word %h (last_word %b)", word, last);
        errors++;
        return;
      end
      dw = owed_words.pop_front();
      if (word !== dw.word) begin
        $error("digest_word: expected %h, actual %h", dw.word, word);
        errors++;
      end
      if (last !== dw.last) begin
        $error("last_word: expected %b, actual %b", dw.last, last);
        errors++;
      end
    endfunction

    function int unsigned words_owed();
      return owed_words.size();
    endfunction
  endclass

endpackage

@@ dv/tb_sha1_message_digest_unit.sv @@
module tb_sha1_message_digest_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sha1_digest_check_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned NUM_ITEMS   = 260;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        has_byte_i = 1'b0;
  logic        end_of_message_i = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] digest_word_o;
  logic        last_word_o;
  logic        empty;
  logic        pop = 1'b0;

  sha1_expected_digests sb;
  int unsigned msg_items;
  int unsigned stall_cycles;
  bit          send_burst;
  bit          drain_burst;

  sha1_message_digest_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .push             (push),
    .full             (full),
    .digest_word_o    (digest_word_o),
    .last_word_o      (last_word_o),
    .empty            (empty),
    .pop              (pop)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(logic [7:0] data, logic has_byte, logic end_msg);
    int unsigned gap;
    gap = send_burst ? 0 : idle_len();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    data_byte_i      <= data;
    has_byte_i       <= has_byte;
    end_of_message_i <= end_msg;
    push             <= 1'b1;
    do @(posedge clk_i); while (full);
    sb.absorb_item(data, has_byte, end_msg);
    msg_items++;
  endtask

  // Ends either on the last byte or with a separate empty end marker; no-op items are
  // scattered in as noise.
  task automatic send_message(int unsigned len, bit marker_end);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, !marker_end && (i == len - 1));
    end
    if (marker_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    int unsigned edges [6] = '{55, 56, 57, 63, 64, 65};
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 12);
    if (r < 90) return edges[$urandom_range(0, 5)];
    return $urandom_range(100, 130);
  endfunction

  initial begin
    int unsigned len;
    sb = new();
    msg_items = 0;
    send_burst = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ignored item, empty message, single-byte extremes, a short text
    // message, and bytes closed by a separate empty end marker.
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h3c, 1'b0, 1'b0);
    send_item(8'hc3, 1'b0, 1'b1);

    while (msg_items < NUM_ITEMS) begin
      send_burst = ($urandom_range(0, 3) == 0);
      len = pick_length();
      if (len > NUM_ITEMS - msg_items) len = NUM_ITEMS - msg_items;
      send_message(len, $urandom_range(0, 2) == 0);
    end
    push <= 1'b0;

    while (sb.words_owed() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.words_owed() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    int unsigned popped;
    popped = 0;
    drain_burst = 1'b0;
    wait (rst_ni);
    forever begin
      gap = drain_burst ? 0 : idle_len();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      sb.check_digest_word(digest_word_o, last_word_o);
      popped++;
      if (popped % 15 == 0) drain_burst = ($urandom_range(0, 2) == 0);
    end
  end

  // A transaction on either side counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end else begin
      stall_cycles <= 0;
    end
  end

endmodule

@@ files.f @@
rtl/sha1md_pkg.sv
rtl/sha1md_fifo.sv
rtl/sha1md_front.sv
rtl/sha1md_core.sv
rtl/sha1_message_digest_unit.sv
dv/sha1_digest_check_pkg.sv
dv/tb_sha1_message_digest_unit.sv
